### rtl/bie_pkg.sv
// Shared types, constants and color helpers for the blended 4-bit icon expander.
// Depends on nothing; used by bie_pixel_lane and blended_4bit_icon_expander_core.
`timescale 1ns / 1ps

package bie_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_IDX = 2'd1;

  // Reset colors
  localparam logic [15:0] FORE_RESET = 16'hFFFF;
  localparam logic [15:0] BACK_RESET = 16'h0000;

  // Register stages of each pixel lane (decode, multiply, sum)
  localparam int PIPE_DEPTH = 3;

  // Blend arithmetic
  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam int BLEND_SHIFT = 9;
  localparam logic [3:0] NIB_BACK = 4'h0;
  localparam logic [3:0] NIB_FORE = 4'hF;

  // Where a pixel comes from
  typedef enum logic [1:0] {
    SEL_BACK,
    SEL_FORE,
    SEL_MIX
  } sel_t;

  // Channels widened to odd values: red/blue 6 bits, green 7 bits
  typedef struct packed {
    logic [5:0] r;
    logic [6:0] g;
    logic [5:0] b;
  } wide_rgb_t;

  // Products of one color with its weight
  typedef struct packed {
    logic [13:0] r;
    logic [14:0] g;
    logic [13:0] b;
  } prod_rgb_t;

  // Widen each RGB565 channel to (c<<1)+1
  function automatic wide_rgb_t widen(input logic [15:0] c);
    wide_rgb_t w;
    w.r = {c[15:11], 1'b1};
    w.g = {c[10:5], 1'b1};
    w.b = {c[4:0], 1'b1};
    return w;
  endfunction

endpackage

### rtl/bie_pixel_lane.sv
// Three-stage palette lookup and blend for one 4-bit nibble.
// Depends on bie_pkg; instantiated twice by blended_4bit_icon_expander_core.
`timescale 1ns / 1ps

module bie_pixel_lane (
  input  logic        clk,
  input  logic [3:0]  nibble,
  input  logic [15:0] fore_color,
  input  logic [15:0] back_color,
  output logic [15:0] pixel
);

  // Stage 1: decode nibble, widen colors, form weights
  bie_pkg::sel_t      s1_sel_r;
  logic [15:0]        s1_raw_r;
  logic [7:0]         s1_alpha_r;
  logic [7:0]         s1_inv_r;
  bie_pkg::wide_rgb_t s1_fg_r;
  bie_pkg::wide_rgb_t s1_bg_r;

  bie_pkg::sel_t      s1_sel_nxt;
  logic [15:0]        s1_raw_nxt;
  logic [7:0]         alpha_nxt;

  always_comb begin
    alpha_nxt = {nibble, 4'b0000};
    if (nibble == bie_pkg::NIB_BACK) begin
      s1_sel_nxt = bie_pkg::SEL_BACK;
      s1_raw_nxt = back_color;
    end else if (nibble == bie_pkg::NIB_FORE) begin
      s1_sel_nxt = bie_pkg::SEL_FORE;
      s1_raw_nxt = fore_color;
    end else begin
      s1_sel_nxt = bie_pkg::SEL_MIX;
      s1_raw_nxt = back_color;
    end
  end

  always_ff @(posedge clk) begin
    s1_sel_r   <= s1_sel_nxt;
    s1_raw_r   <= s1_raw_nxt;
    s1_alpha_r <= alpha_nxt;
    s1_inv_r   <= bie_pkg::ALPHA_FULL - alpha_nxt;
    s1_fg_r    <= bie_pkg::widen(fore_color);
    s1_bg_r    <= bie_pkg::widen(back_color);
  end

  // Stage 2: weight each channel of both colors
  bie_pkg::sel_t      s2_sel_r;
  logic [15:0]        s2_raw_r;
  bie_pkg::prod_rgb_t s2_fp_r;
  bie_pkg::prod_rgb_t s2_bp_r;

  always_ff @(posedge clk) begin
    s2_sel_r  <= s1_sel_r;
    s2_raw_r  <= s1_raw_r;
    s2_fp_r.r <= 14'(s1_fg_r.r * s1_alpha_r);
    s2_fp_r.g <= 15'(s1_fg_r.g * s1_alpha_r);
    s2_fp_r.b <= 14'(s1_fg_r.b * s1_alpha_r);
    s2_bp_r.r <= 14'(s1_bg_r.r * s1_inv_r);
    s2_bp_r.g <= 15'(s1_bg_r.g * s1_inv_r);
    s2_bp_r.b <= 14'(s1_bg_r.b * s1_inv_r);
  end

  // Stage 3: sum, scale down and pack, or pass the exact color
  logic [13:0] sum_r;
  logic [14:0] sum_g;
  logic [13:0] sum_b;
  logic [15:0] pixel_r;
  logic [15:0] pixel_nxt;

  always_comb begin
    sum_r = s2_fp_r.r + s2_bp_r.r;
    sum_g = s2_fp_r.g + s2_bp_r.g;
    sum_b = s2_fp_r.b + s2_bp_r.b;
    case (s2_sel_r)
      bie_pkg::SEL_BACK: pixel_nxt = s2_raw_r;
      bie_pkg::SEL_FORE: pixel_nxt = s2_raw_r;
      bie_pkg::SEL_MIX:  pixel_nxt = {sum_r[13:bie_pkg::BLEND_SHIFT],
                                      sum_g[14:bie_pkg::BLEND_SHIFT],
                                      sum_b[13:bie_pkg::BLEND_SHIFT]};
      default:           pixel_nxt = s2_raw_r;
    endcase
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign pixel = pixel_r;

endmodule

### rtl/blended_4bit_icon_expander_core.sv
// Top level of the blended 4-bit icon expander: config registers, valid pipe, two lanes.
// Depends on bie_pkg and bie_pixel_lane.
`timescale 1ns / 1ps

// Usage:
//   Input: drive in_packed_byte and raise start; a transaction is taken at each
//   rising edge with start high and busy low. busy is held low, so one byte can
//   be taken in every clock cycle.
//   Output: after a byte is taken and has passed the decode, multiply and sum
//   registers of each pixel lane, out_valid is high for exactly one cycle with
//   out_first_pixel (high nibble) and out_second_pixel (low nibble) in RGB565.
//   Throughput is one byte per cycle; each lane has three register stages.
//   The receiver cannot stall; results are strobed and must be captured.
//   Config: cfg_valid/cfg_ready write cfg_data into register cfg_index
//   (0 = foreground, 1 = background); other indexes are ignored. cfg_ready is
//   always high. Write only while no transaction is in flight.
//   Reset (rst_n low, synchronous): foreground goes to 0xFFFF, background to
//   0x0000, and all in-flight transactions are dropped.

module blended_4bit_icon_expander_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_packed_byte,
  output logic                          out_valid,
  output logic [15:0]                   out_first_pixel,
  output logic [15:0]                   out_second_pixel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bie_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  logic [15:0]                    fore_r;
  logic [15:0]                    back_r;
  logic [bie_pkg::PIPE_DEPTH-1:0] valid_r;
  logic                           accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Hold config registers; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= bie_pkg::FORE_RESET;
      back_r <= bie_pkg::BACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bie_pkg::CFG_FORE_IDX) begin
        fore_r <= cfg_data;
      end else if (cfg_index == bie_pkg::CFG_BACK_IDX) begin
        back_r <= cfg_data;
      end
    end
  end

  // Advance valid bits alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[bie_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  // High nibble lane
  bie_pixel_lane u_lane_hi (
    .clk        (clk),
    .nibble     (in_packed_byte[7:4]),
    .fore_color (fore_r),
    .back_color (back_r),
    .pixel      (out_first_pixel)
  );

  // Low nibble lane
  bie_pixel_lane u_lane_lo (
    .clk        (clk),
    .nibble     (in_packed_byte[3:0]),
    .fore_color (fore_r),
    .back_color (back_r),
    .pixel      (out_second_pixel)
  );

  assign out_valid = valid_r[bie_pkg::PIPE_DEPTH-1];

  // Every result traces back to an earlier transaction
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, bie_pkg::PIPE_DEPTH))
    else $error("result strobe without a matching transaction");

  // Every accepted transaction yields a result
  a_start_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(bie_pkg::PIPE_DEPTH) out_valid)
    else $error("transaction dropped in pipeline");

  // Full-intensity high nibble returns the foreground color exactly
  a_fore_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_packed_byte[7:4] == bie_pkg::NIB_FORE, bie_pkg::PIPE_DEPTH))
      |-> (out_first_pixel == $past(fore_r, bie_pkg::PIPE_DEPTH)))
    else $error("nibble 15 does not give the foreground color");

  // Zero low nibble returns the background color exactly
  a_back_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_packed_byte[3:0] == bie_pkg::NIB_BACK, bie_pkg::PIPE_DEPTH))
      |-> (out_second_pixel == $past(back_r, bie_pkg::PIPE_DEPTH)))
    else $error("nibble 0 does not give the background color");

endmodule
